[design/lef_pkg.sv]
// Shared types, constants and the per-channel edge kernel of the Laplacian edge filter.
`default_nettype none

package lef_pkg;

  // Parameter defaults
  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int CHANNELS_DEFAULT  = 3;

  // Channel bytes carried on the pixel ports
  localparam int INPUT_LANES = 3;

  // Configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_COMPONENT_COUNT = 2'd2;

  // Configuration reset values
  localparam logic [11:0] IMAGE_WIDTH_RESET     = 12'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RESET    = 16'd480;
  localparam logic [1:0]  COMPONENT_COUNT_RESET = 2'd3;

  // Smallest frame dimension the window can work on
  localparam logic [11:0] MIN_WIDTH  = 12'd3;
  localparam logic [15:0] MIN_HEIGHT = 16'd3;

  // Clamp ceiling of a result byte
  localparam logic [7:0] PIXEL_MAX = 8'd255;

  // Position and marks that travel with a pixel through the pipeline
  typedef struct packed {
    logic        emit;
    logic [10:0] column;
    logic [15:0] row;
    logic        row_end;
    logic        frame_end;
  } meta_t;

  // Eight times the centre minus the neighbour sum, clamped to 0..255
  function automatic logic [7:0] edge_kernel(input logic [7:0] centre,
                                             input logic [10:0] neighbour_sum);
    logic [11:0] diff;
    logic [7:0]  res;
    diff = {1'b0, centre, 3'b000} - {1'b0, neighbour_sum};
    if (diff[11]) begin
      res = 8'd0;
    end else if (diff[10:8] != 3'd0) begin
      res = PIXEL_MAX;
    end else begin
      res = diff[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[design/lef_line_ram.sv]
// One line store: synchronous single-write, single-read memory with registered read data.
`default_nettype none

module lef_line_ram #(
  parameter int DEPTH = lef_pkg::MAX_WIDTH_DEFAULT,
  parameter int WIDTH = 8 * lef_pkg::CHANNELS_DEFAULT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read old contents first, write the new word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/lef_window_filter.sv]
// 3x3 pixel window, per-channel edge kernel and the output register.
`default_nettype none

module lef_window_filter #(
  parameter int LANES = lef_pkg::INPUT_LANES,
  parameter int PIX_W = 8 * LANES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire logic                  s1_valid,
  input  wire lef_pkg::meta_t        s1_meta,
  input  wire logic [PIX_W-1:0]      up_px,
  input  wire logic [PIX_W-1:0]      mid_px,
  input  wire logic [PIX_W-1:0]      new_px,
  input  wire logic [1:0]            used_channels,
  output logic                       out_valid,
  output lef_pkg::meta_t             out_meta,
  output logic [2:0][7:0]            edge_out
);

  logic [2:0][2:0][PIX_W-1:0] win;
  logic                       s2_valid;
  lef_pkg::meta_t             s2_meta;
  logic [2:0][7:0]            edge_next;

  // Shift the window one column per word
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= up_px;
      win[1][2] <= mid_px;
      win[2][2] <= new_px;
    end
  end

  // Hold the meta of the window centre
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_meta.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_meta <= s1_meta;
    end
  end

  // Filter each stored channel; drop channels not in use
  for (genvar c = 0; c < 3; c++) begin : g_chan
    if (c < LANES) begin : g_live
      logic [10:0] nsum;
      always_comb begin
        nsum = 11'd0;
        for (int r = 0; r < 3; r++) begin
          for (int k = 0; k < 3; k++) begin
            if (!(r == 1 && k == 1)) begin
              nsum = nsum + {3'b000, win[r][k][8*c +: 8]};
            end
          end
        end
        if (2'(c) < used_channels) begin
          edge_next[c] = lef_pkg::edge_kernel(win[1][1][8*c +: 8], nsum);
        end else begin
          edge_next[c] = 8'd0;
        end
      end
    end else begin : g_dead
      assign edge_next[c] = 8'd0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      out_meta <= s2_meta;
      edge_out <= edge_next;
    end
  end

endmodule

`default_nettype wire

[design/laplacian_edge_filter_3x3_core.sv]
// Top level of the 3x3 Laplacian edge filter: configuration, raster counters, line stores.
//
//  channel | words                                   | handshake
//  --------+-----------------------------------------+--------------------
//  in      | sample_c0, sample_c1, sample_c2         | in_valid / in_ready
//  out     | edge_c0..2, out_column, out_row,        | out_valid / out_ready
//          | row_end, frame_end                      |
//  cfg     | cfg_index, cfg_data                     | cfg_valid / cfg_ready
//
// One pixel word is accepted per cycle while the output is not stalled; a result passes the
// line store read, the window shift and the output register after the pixel completing its window.
// Each line store takes one read and one write per pixel, so the rate is one word a cycle without a stall.
// rst clears counters, valid flags and configuration registers; line store contents stay undefined.
// A stalled output holds every stage, and in_ready drops for the same cycle.
`default_nettype none

module laplacian_edge_filter_3x3_core #(
  parameter int MAX_WIDTH = lef_pkg::MAX_WIDTH_DEFAULT,
  parameter int CHANNELS  = lef_pkg::CHANNELS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  sample_c0,
  input  wire logic [7:0]  sample_c1,
  input  wire logic [7:0]  sample_c2,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       edge_c0,
  output logic [7:0]       edge_c1,
  output logic [7:0]       edge_c2,
  output logic [10:0]      out_column,
  output logic [15:0]      out_row,
  output logic             row_end,
  output logic             frame_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int LANES = (CHANNELS < lef_pkg::INPUT_LANES) ? CHANNELS : lef_pkg::INPUT_LANES;
  localparam int PIX_W = 8 * LANES;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XE    = (XW > 11) ? XW : 11;
  localparam int WCAP  = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;

  logic [11:0]      image_width;
  logic [15:0]      image_height;
  logic [1:0]       component_count;
  logic [11:0]      eff_width;
  logic [15:0]      eff_height;
  logic [1:0]       used_channels;

  logic [XW-1:0]    column_count;
  logic [15:0]      row_count;
  logic             col_last;
  logic             row_last;
  logic [XE-1:0]    col_minus;

  logic             advance;
  logic             in_accept;
  logic             cfg_accept;
  logic [23:0]      px_full;
  logic [PIX_W-1:0] px;

  logic             s1_valid;
  lef_pkg::meta_t   s1_meta;
  lef_pkg::meta_t   meta_next;
  logic [PIX_W-1:0] s1_px;
  logic [XW-1:0]    s1_x;
  logic [PIX_W-1:0] up_rd;
  logic [PIX_W-1:0] mid_rd;

  lef_pkg::meta_t   out_meta;
  logic [2:0][7:0]  edge_out;

  // Handshakes
  assign advance    = !out_valid || out_ready;
  assign in_ready   = advance;
  assign in_accept  = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  // Effective frame dimensions and channel count
  always_comb begin
    if (image_width < lef_pkg::MIN_WIDTH) begin
      eff_width = lef_pkg::MIN_WIDTH;
    end else if (image_width > 12'(WCAP)) begin
      eff_width = 12'(WCAP);
    end else begin
      eff_width = image_width;
    end
    eff_height    = (image_height < lef_pkg::MIN_HEIGHT) ? lef_pkg::MIN_HEIGHT : image_height;
    used_channels = (component_count == 2'd0) ? 2'd1 : component_count;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= lef_pkg::IMAGE_WIDTH_RESET;
      image_height    <= lef_pkg::IMAGE_HEIGHT_RESET;
      component_count <= lef_pkg::COMPONENT_COUNT_RESET;
    end else if (cfg_accept) begin
      unique case (cfg_index)
        lef_pkg::REG_IMAGE_WIDTH:     image_width     <= cfg_data[11:0];
        lef_pkg::REG_IMAGE_HEIGHT:    image_height    <= cfg_data;
        lef_pkg::REG_COMPONENT_COUNT: component_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Position of the incoming pixel and its marks
  always_comb begin
    col_last  = (14'(column_count) + 14'd1) >= 14'(eff_width);
    row_last  = (17'(row_count) + 17'd1) >= 17'(eff_height);
    col_minus = XE'(column_count) - XE'(1);
    meta_next.emit      = (column_count >= XW'(2)) && (row_count >= 16'd2);
    meta_next.column    = col_minus[10:0];
    meta_next.row       = row_count - 16'd1;
    meta_next.row_end   = col_last;
    meta_next.frame_end = col_last && row_last;
  end

  // Advance the raster counters; restart the frame on a dimension write
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_accept && (cfg_index == lef_pkg::REG_IMAGE_WIDTH ||
                                cfg_index == lef_pkg::REG_IMAGE_HEIGHT)) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? 16'd0 : row_count + 16'd1;
      end else begin
        column_count <= column_count + XW'(1);
      end
    end
  end

  // Pack the stored channels of the pixel
  assign px_full = {sample_c2, sample_c1, sample_c0};
  assign px      = px_full[PIX_W-1:0];

  // Stage one: line store read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_meta <= meta_next;
      s1_px   <= px;
      s1_x    <= column_count;
    end
  end

  // Middle store takes the new pixel; upper store takes the old middle word
  lef_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PIX_W),
    .AW    (XW)
  ) u_middle_store (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (column_count),
    .rd_data (mid_rd),
    .wr_en   (in_accept),
    .wr_addr (column_count),
    .wr_data (px)
  );

  lef_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PIX_W),
    .AW    (XW)
  ) u_upper_store (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (column_count),
    .rd_data (up_rd),
    .wr_en   (s1_valid && advance),
    .wr_addr (s1_x),
    .wr_data (mid_rd)
  );

  lef_window_filter #(
    .LANES (LANES),
    .PIX_W (PIX_W)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .s1_valid      (s1_valid),
    .s1_meta       (s1_meta),
    .up_px         (up_rd),
    .mid_px        (mid_rd),
    .new_px        (s1_px),
    .used_channels (used_channels),
    .out_valid     (out_valid),
    .out_meta      (out_meta),
    .edge_out      (edge_out)
  );

  // Result ports
  assign edge_c0    = edge_out[0];
  assign edge_c1    = edge_out[1];
  assign edge_c2    = edge_out[2];
  assign out_column = out_meta.column;
  assign out_row    = out_meta.row;
  assign row_end    = out_meta.row_end;
  assign frame_end  = out_meta.frame_end;

  // Counters stay inside the frame; frame end comes with row end; upper store write and read never share a column
  a_column_in_frame: assert property (@(posedge clk) disable iff (rst)
    14'(column_count) < 14'(eff_width))
    else $error("column counter outside the frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    row_count < eff_height)
    else $error("row counter outside the frame height");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!frame_end || row_end))
    else $error("frame end without row end");

  a_upper_write_distinct: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && in_accept) |-> (s1_x != column_count))
    else $error("line store write and read hit the same column");

endmodule

`default_nettype wire

[verif/tb_laplacian_edge_filter_3x3_core.sv]
// Self-checking testbench for the 3x3 Laplacian edge filter core, directed and random frames.
`timescale 1ns / 1ps

module tb_laplacian_edge_filter_3x3_core;

  localparam int MAX_W        = lef_pkg::MAX_WIDTH_DEFAULT;
  localparam int DRAIN_CYC    = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int WIDE_ITEMS   = 200;
  localparam int IDLE_PCT     = 13;

  // Register index the block does not decode
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef logic [2:0][7:0] pixel_t;

  typedef struct packed {
    pixel_t      chan;
    logic [10:0] column;
    logic [15:0] row;
    logic        row_end;
    logic        frame_end;
  } edge_word_t;

  typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_e;
  typedef enum int {TEXTURE_NOISE, TEXTURE_FLAT, TEXTURE_SPIKES} texture_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] index;
    logic [15:0] data;
    pixel_t     px;
    bit         typed;
    edge_word_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  sample_c0 = '0;
  logic [7:0]  sample_c1 = '0;
  logic [7:0]  sample_c2 = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = lef_pkg::REG_IMAGE_WIDTH;
  logic [15:0] cfg_data = '0;
  wire logic        in_ready;
  wire logic        out_valid;
  wire logic        cfg_ready;
  wire logic [7:0]  edge_c0;
  wire logic [7:0]  edge_c1;
  wire logic [7:0]  edge_c2;
  wire logic [10:0] out_column;
  wire logic [15:0] out_row;
  wire logic        row_end;
  wire logic        frame_end;

  // Filter model state and its copy of the registers
  logic [23:0] upper_row [MAX_W];
  logic [23:0] middle_row [MAX_W];
  logic [23:0] win [3][3];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [11:0] width_reg;
  logic [15:0] height_reg;
  logic [1:0]  chan_reg;

  edge_word_t  pending_edges [$];
  edge_word_t  seen_word;
  edge_word_t  oldest_word;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;

  laplacian_edge_filter_3x3_core uut (.*);

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic check_word(input edge_word_t got, input edge_word_t want);
    int c;
    for (c = 0; c < 3; c++) begin
      if (got.chan[c] != want.chan[c])
        report_mismatch($sformatf("edge_c%0d at row %0d col %0d", c, want.row, want.column),
                        got.chan[c], want.chan[c]);
    end
    if (got.column != want.column) report_mismatch("out_column", got.column, want.column);
    if (got.row != want.row) report_mismatch("out_row", got.row, want.row);
    if (got.row_end != want.row_end) report_mismatch("row_end", got.row_end, want.row_end);
    if (got.frame_end != want.frame_end)
      report_mismatch("frame_end", got.frame_end, want.frame_end);
  endtask

  // Shift one pixel through line stores and window; return 1 when a centre is emitted
  function automatic bit filter_pixel(input pixel_t px, output edge_word_t res);
    int unsigned w, h, x, y, used;
    logic [23:0] up, mid, word;
    int acc, v, r, k, c;
    bit emit;
    w = width_reg;
    if (w < lef_pkg::MIN_WIDTH) w = lef_pkg::MIN_WIDTH;
    if (w > MAX_W) w = MAX_W;
    h = (height_reg < lef_pkg::MIN_HEIGHT) ? lef_pkg::MIN_HEIGHT : height_reg;
    x = col_pos;
    y = row_pos;
    word = px;
    up = upper_row[x];
    mid = middle_row[x];
    upper_row[x] = mid;
    middle_row[x] = word;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = word;
    res = '0;
    emit = (x >= 2) && (y >= 2);
    if (emit) begin
      used = (chan_reg == 2'd0) ? 1 : chan_reg;
      for (c = 0; c < 3; c++) begin
        acc = 0;
        for (r = 0; r < 3; r++) begin
          for (k = 0; k < 3; k++) begin
            v = win[r][k][8*c +: 8];
            acc += (r == 1 && k == 1) ? 8 * v : -v;
          end
        end
        if (acc < 0) acc = 0;
        if (acc > lef_pkg::PIXEL_MAX) acc = lef_pkg::PIXEL_MAX;
        if (c < used) res.chan[c] = acc[7:0];
      end
      res.column = 11'(x - 1);
      res.row = 16'(y - 1);
      res.row_end = (x + 1 == w);
      res.frame_end = (x + 1 == w) && (y + 1 == h);
    end
    // Advance the raster position
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
    return emit;
  endfunction

  function automatic void apply_cfg(input logic [1:0] idx, input logic [15:0] val);
    case (idx)
      lef_pkg::REG_IMAGE_WIDTH: begin
        width_reg = val[11:0];
        col_pos = 0;
        row_pos = 0;
      end
      lef_pkg::REG_IMAGE_HEIGHT: begin
        height_reg = val;
        col_pos = 0;
        row_pos = 0;
      end
      lef_pkg::REG_COMPONENT_COUNT: begin
        chan_reg = val[1:0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic pixel_t make_pixel(input texture_e texture, input logic [7:0] base);
    pixel_t px;
    int c, v;
    for (c = 0; c < 3; c++) begin
      case (texture)
        TEXTURE_NOISE: begin
          px[c] = 8'($urandom_range(255));
        end
        TEXTURE_FLAT: begin
          v = base + $urandom_range(15);
          if (v > lef_pkg::PIXEL_MAX) v = lef_pkg::PIXEL_MAX;
          px[c] = v[7:0];
        end
        default: begin
          px[c] = $urandom_range(1) ? lef_pkg::PIXEL_MAX : 8'd0;
        end
      endcase
    end
    return px;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [15:0] val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.index = idx;
    row.data = val;
    row.px = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t pix_row(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2, input bit typed = 1'b0,
                                        input edge_word_t want = '0);
    stim_row_t row;
    row.kind = ROW_PIXEL;
    row.index = lef_pkg::REG_IMAGE_WIDTH;
    row.data = '0;
    row.px = {c2, c1, c0};
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  // Hold off input until every pending word has come out, then let the pipe settle
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_cfg(idx, val);
  endtask

  task automatic send_pixel(input pixel_t px, input bit typed = 1'b0,
                            input edge_word_t want = '0);
    edge_word_t predicted;
    bit emit;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {sample_c2, sample_c1, sample_c0} <= px;
    do @(posedge clk); while (!in_ready);
    emit = filter_pixel(px, predicted);
    if (emit) pending_edges.push_back(typed ? want : predicted);
  endtask

  task automatic run_directed();
    stim_row_t rows [$];
    // Undersized dimensions act as 3x3; junk above bit 11 of the width is dropped
    rows.push_back(cfg_row(lef_pkg::REG_IMAGE_WIDTH, 16'hF001));
    rows.push_back(cfg_row(lef_pkg::REG_IMAGE_HEIGHT, 16'h0000));
    rows.push_back(cfg_row(lef_pkg::REG_COMPONENT_COUNT, 16'h0003));
    // Bright centre on dark neighbours in c0/c2, the inverse in c1
    repeat (4) rows.push_back(pix_row(8'd0, 8'd255, 8'd0));
    rows.push_back(pix_row(8'd255, 8'd0, 8'd255));
    repeat (3) rows.push_back(pix_row(8'd0, 8'd255, 8'd0));
    rows.push_back(pix_row(8'd0, 8'd255, 8'd0, 1'b1,
                           '{chan: {8'd255, 8'd0, 8'd255}, column: 11'd1, row: 16'd1,
                             row_end: 1'b1, frame_end: 1'b1}));
    // Zero channel count acts as one; the unused index is ignored
    rows.push_back(cfg_row(lef_pkg::REG_COMPONENT_COUNT, 16'h0000));
    rows.push_back(cfg_row(REG_UNUSED, 16'hFFFF));
    repeat (4) rows.push_back(pix_row(8'd0, 8'd0, 8'd0));
    rows.push_back(pix_row(8'd255, 8'd255, 8'd255));
    repeat (3) rows.push_back(pix_row(8'd0, 8'd0, 8'd0));
    rows.push_back(pix_row(8'd0, 8'd0, 8'd0, 1'b1,
                           '{chan: {8'd0, 8'd0, 8'd255}, column: 11'd1, row: 16'd1,
                             row_end: 1'b1, frame_end: 1'b1}));
    // Partial frame, restarted by the next dimension write
    repeat (4) rows.push_back(pix_row(8'($urandom), 8'($urandom), 8'($urandom)));
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_reg(rows[i].index, rows[i].data);
      end else begin
        send_pixel(rows[i].px, rows[i].typed, rows[i].want);
      end
    end
  endtask

  task automatic run_random();
    int unsigned sent, phase, f, frames, i, n, w, h, switch_at;
    logic [11:0] w_raw;
    logic [15:0] h_raw;
    texture_e texture;
    logic [7:0] base;
    // Oversized width clamps to a full line; a partial first row emits nothing
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
    write_reg(lef_pkg::REG_COMPONENT_COUNT, 16'h0003);
    base = 8'($urandom);
    for (i = 0; i < WIDE_ITEMS; i++) send_pixel(make_pixel(TEXTURE_FLAT, base));
    sent = WIDE_ITEMS;
    // Small frames with random geometry, some cut short
    for (phase = 0; sent < RANDOM_ITEMS; phase++) begin
      quiet = (phase >= 8) && (phase < 18);
      w_raw = ($urandom_range(4) == 0) ? 12'($urandom_range(2)) : 12'($urandom_range(3, 12));
      h_raw = ($urandom_range(4) == 0) ? 16'($urandom_range(2)) : 16'($urandom_range(3, 7));
      w = (w_raw < lef_pkg::MIN_WIDTH) ? lef_pkg::MIN_WIDTH : w_raw;
      h = (h_raw < lef_pkg::MIN_HEIGHT) ? lef_pkg::MIN_HEIGHT : h_raw;
      write_reg(lef_pkg::REG_IMAGE_WIDTH, {4'($urandom), w_raw});
      write_reg(lef_pkg::REG_IMAGE_HEIGHT, h_raw);
      write_reg(lef_pkg::REG_COMPONENT_COUNT, {14'($urandom), 2'($urandom)});
      if ($urandom_range(5) == 0) write_reg(REG_UNUSED, 16'($urandom));
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        n = w * h;
        if (f == frames - 1 && $urandom_range(4) == 0) n = $urandom_range(1, n - 1);
        switch_at = ($urandom_range(3) == 0) ? $urandom_range(1, n - 1) : n;
        texture = texture_e'($urandom_range(2));
        base = 8'($urandom);
        for (i = 0; i < n; i++) begin
          // Change the channel count mid-frame
          if (i == switch_at)
            write_reg(lef_pkg::REG_COMPONENT_COUNT, {14'($urandom), 2'($urandom)});
          send_pixel(make_pixel(texture, base));
        end
        sent += n;
      end
    end
    quiet = 1'b0;
  endtask

  // Check each output word against the oldest prediction and pick the next ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_word = {edge_c2, edge_c1, edge_c0, out_column, out_row, row_end, frame_end};
        if (pending_edges.size() == 0) begin
          report_mismatch("out_valid with no word pending", 1, 0);
        end else begin
          oldest_word = pending_edges.pop_front();
          check_word(seen_word, oldest_word);
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Stop a hung run: count cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) win[r][k] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    width_reg = lef_pkg::IMAGE_WIDTH_RESET;
    height_reg = lef_pkg::IMAGE_HEIGHT_RESET;
    chan_reg = lef_pkg::COMPONENT_COUNT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    drain_pipeline();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/lef_pkg.sv
design/lef_line_ram.sv
design/lef_window_filter.sv
design/laplacian_edge_filter_3x3_core.sv
verif/tb_laplacian_edge_filter_3x3_core.sv
